### src/mdio_pkg.sv
// Shared types and constants for the MDIO management master.
`default_nettype none

package mdio_pkg;

  localparam int DATA_BITS = 16;
  localparam int PRE_W     = 6;
  localparam int ADDR_W    = 5;
  localparam int POS_W     = 7;
  localparam int BODY_BASE = 64;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;
  localparam logic [1:0] ACT_NOP   = 2'd3;

  localparam logic CFG_PREAMBLE = 1'b0;
  localparam logic CFG_MAX_PHY  = 1'b1;

  localparam logic [PRE_W-1:0]  PREAMBLE_RESET = 6'd32;
  localparam logic [ADDR_W-1:0] MAX_PHY_RESET  = 5'd8;

  typedef struct packed {
    logic                   is_tick;
    logic                   is_start;
    logic                   start_read;
    logic [2*ADDR_W-1:0]    address_bits;
    logic [DATA_BITS-1:0]   write_data;
    logic                   sample;
  } mdio_item_t;

  typedef struct packed {
    logic             write;
    logic             index;
    logic [PRE_W-1:0] data;
  } cfg_req_t;

  typedef struct packed {
    logic                 clock_pulse;
    logic                 line_drive;
    logic                 line_level;
    logic                 busy_res;
    logic                 done_res;
    logic [DATA_BITS-1:0] read_value;
    logic                 rejected;
  } mdio_result_t;

endpackage

`default_nettype wire

### src/mdio_management_master.sv
// Top level of the clause-22 MDIO management master.
//
//   channel  direction  handshake            payload
//   in       request    in_valid / in_stall  action, phy_address, register_address,
//                                            write_data, mdio_sample
//   out      result     out_valid/out_stall  clock_pulse, line_drive, line_level,
//                                            busy_res, done_res, read_value, rejected
//   cfg      write      cfg_write            cfg_index, cfg_data
//
// One request per cycle sustained while the output does not stall; each request
// yields one result: the queue slot is written at the accepting edge, the result
// register when the frame sequencer pops the item from the queue head.
// The frame sequencer handles one request per cycle from the queue head unless stalled.
// Reset returns the configuration registers to their defaults and empties the queue.
// in_stall rises only while the queue is full; an output stall backs up the queue.
`default_nettype none

module mdio_management_master
  import mdio_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           action,
  input  wire logic [ADDR_W-1:0]    phy_address,
  input  wire logic [ADDR_W-1:0]    register_address,
  input  wire logic [DATA_BITS-1:0] write_data,
  input  wire logic                 mdio_sample,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      clock_pulse,
  output logic                      line_drive,
  output logic                      line_level,
  output logic                      busy_res,
  output logic                      done_res,
  output logic [DATA_BITS-1:0]      read_value,
  output logic                      rejected,
  input  wire logic                 cfg_write,
  input  wire logic                 cfg_index,
  input  wire logic [PRE_W-1:0]     cfg_data
);

  mdio_item_t   front_item;
  mdio_item_t   head_item;
  mdio_result_t result;
  cfg_req_t     cfg;
  logic         queue_full;
  logic         queue_empty;
  logic         head_pop;

  assign cfg.write = cfg_write;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  assign in_stall = queue_full;

  mdio_front u_front (
    .action           (action),
    .phy_address      (phy_address),
    .register_address (register_address),
    .write_data       (write_data),
    .mdio_sample      (mdio_sample),
    .item             (front_item)
  );

  mdio_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid && !queue_full),
    .push_item (front_item),
    .full      (queue_full),
    .pop       (head_pop),
    .pop_item  (head_item),
    .empty     (queue_empty)
  );

  mdio_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_avail (!queue_empty),
    .item       (head_item),
    .item_pop   (head_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result     (result)
  );

  assign clock_pulse = result.clock_pulse;
  assign line_drive  = result.line_drive;
  assign line_level  = result.line_level;
  assign busy_res    = result.busy_res;
  assign done_res    = result.done_res;
  assign read_value  = result.read_value;
  assign rejected    = result.rejected;

endmodule

`default_nettype wire

### src/mdio_front.sv
// Front end: decode the incoming request into a queue item.
`default_nettype none

module mdio_front
  import mdio_pkg::*;
(
  input  wire logic [1:0]           action,
  input  wire logic [ADDR_W-1:0]    phy_address,
  input  wire logic [ADDR_W-1:0]    register_address,
  input  wire logic [DATA_BITS-1:0] write_data,
  input  wire logic                 mdio_sample,
  output mdio_item_t                item
);

  always_comb begin
    item.is_tick      = 1'b0;
    item.is_start     = 1'b0;
    item.start_read   = 1'b0;
    item.address_bits = {phy_address, register_address};
    item.write_data   = write_data;
    item.sample       = mdio_sample;
    unique case (action)
      ACT_TICK:  item.is_tick = 1'b1;
      ACT_READ:  begin
        item.is_start   = 1'b1;
        item.start_read = 1'b1;
      end
      ACT_WRITE: item.is_start = 1'b1;
      ACT_NOP:   item.is_tick = 1'b0;
      default:   item.is_tick = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

### src/mdio_queue.sv
// Small request queue between the front end and the frame sequencer.
`default_nettype none

module mdio_queue
  import mdio_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire mdio_item_t push_item,
  output logic            full,
  input  wire logic       pop,
  output mdio_item_t      pop_item,
  output logic            empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mdio_item_t           slots [DEPTH];
  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W-1:0]     rd_ptr;
  logic [CNT_W-1:0]     count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_item = slots[rd_ptr];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

### src/mdio_back.sv
// Back end: frame sequencer, configuration registers and result register.
`default_nettype none

module mdio_back
  import mdio_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_req_t   cfg,
  input  wire logic       item_avail,
  input  wire mdio_item_t item,
  output logic            item_pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output mdio_result_t    result
);

  logic [PRE_W-1:0]      preamble_length;
  logic [ADDR_W-1:0]     max_phy_address;

  logic [POS_W-1:0]      frame_position;
  logic                  is_read;
  logic [2*ADDR_W-1:0]   address_bits;
  logic [DATA_BITS-1:0]  data_shift;
  logic                  sample_pending;
  logic                  active;

  logic [POS_W-1:0]      frame_position_next;
  logic                  is_read_next;
  logic [2*ADDR_W-1:0]   address_bits_next;
  logic [DATA_BITS-1:0]  data_shift_next;
  logic                  sample_pending_next;
  logic                  active_next;

  mdio_result_t          result_next;
  logic [PRE_W-1:0]      b;
  logic [3:0]            addr_idx;
  logic [DATA_BITS-1:0]  shifted;

  assign item_pop = item_avail && (!out_valid || !out_stall);

  always_comb begin
    result_next         = '0;
    frame_position_next = frame_position;
    is_read_next        = is_read;
    address_bits_next   = address_bits;
    data_shift_next     = data_shift;
    sample_pending_next = sample_pending;
    active_next         = active;
    b                   = frame_position[PRE_W-1:0];
    addr_idx            = 4'(6'd13 - b);
    shifted             = sample_pending ? {data_shift[DATA_BITS-2:0], item.sample}
                                         : data_shift;
    if (item.is_start) begin
      if (active || (item.address_bits[2*ADDR_W-1:ADDR_W] > max_phy_address)) begin
        result_next.rejected = 1'b1;
      end else begin
        active_next         = 1'b1;
        is_read_next        = item.start_read;
        address_bits_next   = item.address_bits;
        data_shift_next     = item.start_read ? '0 : item.write_data;
        sample_pending_next = 1'b0;
        frame_position_next = POS_W'(BODY_BASE) - {1'b0, preamble_length};
      end
    end else if (item.is_tick && active) begin
      data_shift_next     = shifted;
      sample_pending_next = 1'b0;
      if (!frame_position[POS_W-1]) begin
        result_next.clock_pulse = 1'b1;
        result_next.line_drive  = 1'b1;
        result_next.line_level  = 1'b1;
      end else if (b < 6'd14) begin
        result_next.clock_pulse = 1'b1;
        result_next.line_drive  = 1'b1;
        if (b < 6'd2) begin
          result_next.line_level = b[0];
        end else if (b < 6'd4) begin
          result_next.line_level = is_read ? (b == 6'd2) : (b == 6'd3);
        end else begin
          result_next.line_level = address_bits[addr_idx];
        end
      end else if (!is_read) begin
        if (b < 6'd16) begin
          result_next.clock_pulse = 1'b1;
          result_next.line_drive  = 1'b1;
          result_next.line_level  = (b == 6'd14);
        end else if (b < 6'(16 + DATA_BITS)) begin
          result_next.clock_pulse = 1'b1;
          result_next.line_drive  = 1'b1;
          result_next.line_level  = shifted[~b[3:0]];
        end else begin
          result_next.done_res = 1'b1;
        end
      end else begin
        if (b == 6'd14) begin
          result_next.clock_pulse = 1'b0;
        end else if (b < 6'(16 + DATA_BITS)) begin
          result_next.clock_pulse = 1'b1;
          if (b >= 6'd16) begin
            sample_pending_next = 1'b1;
          end
        end else if (b == 6'(16 + DATA_BITS)) begin
          result_next.clock_pulse = 1'b1;
          result_next.line_drive  = 1'b1;
          result_next.line_level  = 1'b1;
        end else begin
          result_next.done_res   = 1'b1;
          result_next.read_value = shifted;
        end
      end
      if (result_next.done_res) begin
        active_next         = 1'b0;
        frame_position_next = '0;
        sample_pending_next = 1'b0;
      end else begin
        frame_position_next = frame_position + POS_W'(1);
      end
    end
    result_next.busy_res = active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      preamble_length <= PREAMBLE_RESET;
      max_phy_address <= MAX_PHY_RESET;
    end else if (cfg.write) begin
      unique case (cfg.index)
        CFG_PREAMBLE: preamble_length <= cfg.data;
        CFG_MAX_PHY:  max_phy_address <= cfg.data[ADDR_W-1:0];
        default:      preamble_length <= preamble_length;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position <= '0;
      is_read        <= 1'b0;
      address_bits   <= '0;
      data_shift     <= '0;
      sample_pending <= 1'b0;
      active         <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (item_pop) begin
        frame_position <= frame_position_next;
        is_read        <= is_read_next;
        address_bits   <= address_bits_next;
        data_shift     <= data_shift_next;
        sample_pending <= sample_pending_next;
        active         <= active_next;
        out_valid      <= 1'b1;
      end else if (!out_stall) begin
        out_valid      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire
